// File: sv/cse_pkg.sv
package cse_pkg;
    localparam int PIX_W = 24;
    localparam int MAX_LINE = 2048;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN    = 2'd2;

    // one classified pixel handed from the front to the back
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [10:0]      col;
        logic [11:0]      row;
        logic             interior;
        logic             border;
    } job_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } res_t;

    function automatic logic [7:0] filt(input logic [7:0] v [9], input logic [7:0] lo);
        logic signed [11:0] a0, a1, a2, a3;
        logic [13:0] tot;
        logic [12:0] r;
        a0 = -$signed({4'd0,v[0]}) + $signed({4'd0,v[2]}) - $signed({3'd0,v[3],1'b0})
             + $signed({3'd0,v[5],1'b0}) - $signed({4'd0,v[6]}) + $signed({4'd0,v[8]});
        a1 = $signed({4'd0,v[1]}) + $signed({3'd0,v[2],1'b0}) - $signed({4'd0,v[3]})
             + $signed({4'd0,v[5]}) - $signed({3'd0,v[6],1'b0}) - $signed({4'd0,v[7]});
        a2 = $signed({4'd0,v[0]}) + $signed({3'd0,v[1],1'b0}) + $signed({4'd0,v[2]})
             - $signed({4'd0,v[6]}) - $signed({3'd0,v[7],1'b0}) - $signed({4'd0,v[8]});
        a3 = $signed({3'd0,v[0],1'b0}) + $signed({4'd0,v[1]}) + $signed({4'd0,v[3]})
             - $signed({4'd0,v[5]}) - $signed({4'd0,v[7]}) - $signed({3'd0,v[8],1'b0});
        tot = 14'(a0[11] ? -a0 : a0) + 14'(a1[11] ? -a1 : a1)
            + 14'(a2[11] ? -a2 : a2) + 14'(a3[11] ? -a3 : a3);
        r = 13'(tot >> 2);
        if (r < {5'd0, lo}) r = {5'd0, lo};
        if (r > 13'd255) r = 13'd255;
        return r[7:0];
    endfunction
endpackage

// File: sv/cse_front.sv
module cse_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                restart,
    input  logic [11:0]         eff_w,
    input  logic [11:0]         eff_h,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         in_px,
    output logic                job_valid,
    input  logic                job_ready,
    output cse_pkg::job_t       job
);
    import cse_pkg::*;
    localparam int AW = $clog2(MAX_LINE);

    logic [PIX_W-1:0] older_mem [MAX_LINE];
    logic [PIX_W-1:0] newer_mem [MAX_LINE];
    logic [10:0] col_reg;
    logic [11:0] row_reg;
    logic        job_valid_reg;
    job_t        job_reg;
    logic        fire;
    logic [AW-1:0] addr;

    // read data comes registered straight into the job register
    assign in_ready  = !job_valid_reg || job_ready;
    assign fire      = in_valid && in_ready;
    assign addr      = AW'(col_reg);
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            older_mem[addr] <= newer_mem[addr];
            newer_mem[addr] <= in_px;
            job_reg.top <= older_mem[addr];
            job_reg.mid <= newer_mem[addr];
            job_reg.px  <= in_px;
            job_reg.col <= col_reg;
            job_reg.row <= row_reg;
            job_reg.interior <= (row_reg >= 12'd2) && (col_reg >= 11'd2);
            job_reg.border <= (row_reg == 12'd0) || (row_reg == eff_h - 12'd1)
                           || (col_reg == 11'd0) || ({1'b0, col_reg} == eff_w - 12'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (fire) begin
            if ({1'b0, col_reg} + 12'd1 >= eff_w) begin
                col_reg <= '0;
                row_reg <= (row_reg + 12'd1 >= eff_h) ? 12'd0 : row_reg + 12'd1;
            end else begin
                col_reg <= col_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (in_ready) begin
            job_valid_reg <= in_valid;
        end
    end
endmodule

// File: sv/cse_back.sv
module cse_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    min_level,
    input  logic          job_valid,
    output logic          job_ready,
    input  cse_pkg::job_t job,
    output logic          res_valid,
    input  logic          res_ready,
    output cse_pkg::res_t res
);
    import cse_pkg::*;

    logic [PIX_W-1:0] win_reg [6];
    // stage 1: filter result plus pending border item
    logic  s1_valid_reg;
    res_t  s1_int_reg, s1_bor_reg;
    logic  s1_hasint_reg, s1_hasbor_reg;
    logic  s1_phase_reg;
    logic  take, s1_done, s1_hold;
    logic [7:0] v [3][9];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            v[ch][0] = win_reg[0][ch*8 +: 8]; v[ch][1] = win_reg[3][ch*8 +: 8];
            v[ch][2] = job.top[ch*8 +: 8];
            v[ch][3] = win_reg[1][ch*8 +: 8]; v[ch][4] = win_reg[4][ch*8 +: 8];
            v[ch][5] = job.mid[ch*8 +: 8];
            v[ch][6] = win_reg[2][ch*8 +: 8]; v[ch][7] = win_reg[5][ch*8 +: 8];
            v[ch][8] = job.px[ch*8 +: 8];
        end
    end

    // two results leave one per cycle while res_ready is high; the second phase is the border item
    assign s1_hold = s1_valid_reg && s1_hasint_reg && s1_hasbor_reg && !s1_phase_reg;
    assign s1_done = !s1_valid_reg || (res_ready && !s1_hold);
    assign job_ready = s1_done;
    assign take = job_valid && job_ready;

    always_ff @(posedge aclk) begin
        if (take) begin
            win_reg[0] <= win_reg[3]; win_reg[1] <= win_reg[4]; win_reg[2] <= win_reg[5];
            win_reg[3] <= job.top; win_reg[4] <= job.mid; win_reg[5] <= job.px;
            s1_int_reg <= '{filt(v[0], min_level), filt(v[1], min_level),
                            filt(v[2], min_level), job.col - 11'd1, job.row - 12'd1,
                            !job.border};
            s1_bor_reg <= '{job.px[7:0], job.px[15:8], job.px[23:16],
                            job.col, job.row, 1'b1};
            s1_hasint_reg <= job.interior;
            s1_hasbor_reg <= job.border;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end else begin
            if (s1_done) begin
                s1_valid_reg <= take && (job.interior || job.border);
                s1_phase_reg <= 1'b0;
            end else if (res_ready && s1_hold) begin
                s1_phase_reg <= 1'b1;
            end
        end
    end

    assign res_valid = s1_valid_reg;
    assign res = (s1_hasint_reg && !s1_phase_reg) ? s1_int_reg : s1_bor_reg;

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && s1_hold) |-> !res.last) else $error("early last");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_phase_reg |-> (s1_hasint_reg && s1_hasbor_reg)) else $error("bad phase");
endmodule

// File: sv/compass_sobel_edge_filter.sv
// Compass Sobel edge filter: three-channel 8-bit pixels stream in raster order
// at one per clock unless stalled; each interior pixel is replaced by the
// clamped, scaled sum of its absolute compass Sobel responses, and border
// pixels pass through. A result for interior (x,y) is computed from pixel
// (x+1,y+1) via the front job register and the back stage-1 register. An
// input that causes two results (interior then border) holds the input side
// while the single output port sends both. Writing width or height restarts
// the frame at (0,0). Line stores: two MAX_LINE x 24 memories, no clearing pass.
module compass_sobel_edge_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_blue, in_red, in_green
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_blue, out_red, out_green, out_col, out_row, pad
    output logic        m_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cse_pkg::*;

    logic [11:0] width_reg, height_reg;
    logic [7:0]  min_reg;
    logic        wr, restart;
    logic [11:0] eff_w, eff_h;
    logic        job_valid, job_ready, res_valid;
    job_t        job;
    res_t        res;
    logic [1:0]  idx;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign idx     = paddr[3:2];
    assign restart = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            min_reg    <= 8'd33;
        end else if (wr) begin
            case (idx)
                REG_WIDTH:  width_reg  <= pwdata[11:0];
                REG_HEIGHT: height_reg <= pwdata[11:0];
                REG_MIN:    min_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH:  prdata = {20'd0, width_reg};
            REG_HEIGHT: prdata = {20'd0, height_reg};
            REG_MIN:    prdata = {24'd0, min_reg};
            default:    prdata = '0;
        endcase
    end

    // saturate geometry
    always_comb begin
        eff_w = width_reg;
        if (eff_w < 12'd3) eff_w = 12'd3;
        if (32'(eff_w) > MAX_LINE) eff_w = 12'(MAX_LINE);
        eff_h = (height_reg < 12'd3) ? 12'd3 : height_reg;
    end

    cse_front u_front (
        .aclk, .aresetn, .restart, .eff_w, .eff_h,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_px(s_tdata),
        .job_valid, .job_ready, .job
    );

    cse_back u_back (
        .aclk, .aresetn, .min_level(min_reg),
        .job_valid, .job_ready, .job,
        .res_valid, .res_ready(m_tready), .res
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {1'b0, res.row, res.col, res.green, res.red, res.blue};
    assign m_tlast  = res.last;
endmodule

// File: dv/tb_compass_sobel_edge_filter.sv
module tb_compass_sobel_edge_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import cse_pkg::*;

    localparam int LINE_MAX    = 2048;
    localparam int STALL_LIMIT = 4000;  // cycles without any transaction

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // in_blue, in_red, in_green
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // out_blue, out_red, out_green, out_col, out_row, pad
    logic        m_tlast;        // run_last
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    compass_sobel_edge_filter uut (.*);

    initial forever #1 aclk = ~aclk;

    // pixels waiting to be sent, and filter outputs still owed by the block
    logic [23:0] pixel_queue[$];
    res_t        owed_pixels[$];

    int errors = 0, pixels_sent = 0, pixels_seen = 0, frames_started = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;

    // shadow of the block: configuration, line stores, window and position
    logic [11:0] sh_width = 12'd640, sh_height = 12'd480;
    logic [7:0]  sh_min = 8'd33;
    logic [23:0] row_old[LINE_MAX];
    logic [23:0] row_new[LINE_MAX];
    logic [23:0] win_cols[6];
    int          cur_col = 0, cur_row = 0;

    function automatic int used_width();
        int w;
        w = sh_width;
        if (w < 3) w = 3;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = sh_height;
        if (h < 3) h = 3;
        return h;
    endfunction

    // sum of |response| over four of the eight compass kernels (the rest are negations),
    // scaled by 2/8, clamped to [min, 255]
    function automatic logic [7:0] edge_channel(logic [23:0] w9[9], int sh, logic [7:0] lo);
        int v[9];
        int g0, g1, g2, g3, total;
        for (int i = 0; i < 9; i++) v[i] = (w9[i] >> sh) & 8'hFF;
        g0 = -v[0] + v[2] - 2*v[3] + 2*v[5] - v[6] + v[8];
        g1 = v[1] + 2*v[2] - v[3] + v[5] - 2*v[6] - v[7];
        g2 = v[0] + 2*v[1] + v[2] - v[6] - 2*v[7] - v[8];
        g3 = 2*v[0] + v[1] + v[3] - v[5] - v[7] - 2*v[8];
        total = (g0 < 0 ? -g0 : g0) + (g1 < 0 ? -g1 : g1)
              + (g2 < 0 ? -g2 : g2) + (g3 < 0 ? -g3 : g3);
        total = (total * 2) >> 3;
        if (total < lo) total = lo;
        if (total > 255) total = 255;
        return total[7:0];
    endfunction

    // advance the shadow by one accepted pixel and queue what it must produce
    function automatic void predict_pixel(logic [23:0] px);
        int w, h, c, r;
        logic [23:0] top, mid;
        logic [23:0] w9[9];
        res_t o;
        res_t outs[$];
        w = used_width();
        h = used_height();
        c = (cur_col >= w) ? 0 : cur_col;
        r = (cur_row >= h) ? 0 : cur_row;
        top = row_old[c];
        mid = row_new[c];
        if (r >= 2 && c >= 2) begin
            w9 = '{win_cols[0], win_cols[3], top, win_cols[1], win_cols[4], mid,
                   win_cols[2], win_cols[5], px};
            o.blue  = edge_channel(w9, 0, sh_min);
            o.red   = edge_channel(w9, 8, sh_min);
            o.green = edge_channel(w9, 16, sh_min);
            o.col   = 11'(c - 1);
            o.row   = 12'(r - 1);
            o.last  = 1'b0;
            outs.push_back(o);
        end
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
            o.blue  = px[7:0];
            o.red   = px[15:8];
            o.green = px[23:16];
            o.col   = 11'(c);
            o.row   = 12'(r);
            o.last  = 1'b0;
            outs.push_back(o);
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) owed_pixels.push_back(outs[i]);
        row_old[c] = mid;
        row_new[c] = px;
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_col = c;
        cur_row = r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // true when the pixel on the bus was just taken, so it may be dropped
    logic pixels_sent_at_edge = 1'b0;
    always @(posedge aclk) pixels_sent_at_edge <= s_tvalid && s_tready;

    // driver: hold the current pixel until taken, then advance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_pixel(pixel_queue.pop_front());
            pixels_sent++;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_queue[0];
            end else if (!s_tvalid || pixel_queue.size() == 0 ||
                         pixels_sent_at_edge) begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each output transaction with the oldest owed pixel
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            pixels_seen++;
            if (owed_pixels.size() == 0) begin
                report_mismatch("unexpected output (col)", m_tdata[34:24], -1);
            end else begin
                want = owed_pixels.pop_front();
                if (m_tdata[7:0] !== want.blue)
                    report_mismatch("out_blue", m_tdata[7:0], want.blue);
                if (m_tdata[15:8] !== want.red)
                    report_mismatch("out_red", m_tdata[15:8], want.red);
                if (m_tdata[23:16] !== want.green)
                    report_mismatch("out_green", m_tdata[23:16], want.green);
                if (m_tdata[34:24] !== want.col)
                    report_mismatch("out_col", m_tdata[34:24], want.col);
                if (m_tdata[46:35] !== want.row)
                    report_mismatch("out_row", m_tdata[46:35], want.row);
                if (m_tlast !== want.last)
                    report_mismatch("run_last", m_tlast, want.last);
            end
        end
    end

    // watchdog: count cycles with work outstanding but no transaction at all
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pixel_queue.size() == 0 && owed_pixels.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d pixels owed", owed_pixels.size());
            $display("tb_compass_sobel_edge_filter NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // register write: setup cycle, access cycle, update shadow on the write edge
    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_WIDTH: begin
                sh_width = val[11:0];
                cur_col = 0;
                cur_row = 0;
            end
            REG_HEIGHT: begin
                sh_height = val[11:0];
                cur_col = 0;
                cur_row = 0;
            end
            REG_MIN: sh_min = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every owed pixel is out, then let the pipeline settle
    task automatic drain();
        while (pixel_queue.size() > 0 || owed_pixels.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h, int lo);
        drain();
        cfg_write(REG_WIDTH, 32'(w));
        cfg_write(REG_HEIGHT, 32'(h));
        cfg_write(REG_MIN, 32'(lo));
        frames_started++;
    endtask

    // one random frame, sometimes cut short or split by a threshold change
    task automatic random_frame();
        int w, h, lo, n, cut;
        w  = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
        h  = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
        lo = $urandom_range(3) == 0 ? ($urandom_range(1) ? 255 : 0) : $urandom_range(60);
        set_frame(w, h, lo);
        if (w < 3) w = 3;
        if (h < 3) h = 3;
        // two frames in a row exercise the wrap back to the origin
        n = w * h * ($urandom_range(3) == 0 ? 2 : 1);
        if ($urandom_range(5) == 0) n = $urandom_range(1, n);
        cut = ($urandom_range(4) == 0) ? $urandom_range(1, n) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == cut) begin
                drain();
                cfg_write(REG_MIN, $urandom_range(255));
            end
            pixel_queue.push_back(($urandom_range(5) == 0) ?
                ($urandom_range(1) ? 24'hFFFFFF : 24'h000000) : 24'($urandom()));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase one: sender idles a little, receiver a lot
        send_idle_pct = 21;
        recv_idle_pct = 82;
        // checkerboard of extremes in the smallest frame, no floor
        set_frame(3, 3, 0);
        for (int i = 0; i < 9; i++) pixel_queue.push_back((i % 2) ? 24'hFFFFFF : 24'h000000);
        // alternating bit patterns, floor at full scale
        set_frame(4, 3, 255);
        for (int i = 0; i < 12; i++)
            pixel_queue.push_back((i % 3 == 0) ? 24'hAA55AA : (i % 3 == 1) ? 24'h55AA55 : 24'h0);
        while (pixels_sent < 230) random_frame();

        // phase two: roles swapped
        drain();
        send_idle_pct = 82;
        recv_idle_pct = 21;
        while (pixels_sent < 460) random_frame();

        // phase three: full rate both ways, including the widest lines
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pixels_sent < 680) random_frame();
        set_frame(4095, 3, 33);      // width saturates to the line store size
        for (int i = 0; i < 40; i++) pixel_queue.push_back(24'($urandom()));
        set_frame(3, 4095, 255);     // tallest frame, cut short after a few rows
        for (int i = 0; i < 30; i++) pixel_queue.push_back(24'($urandom()));
        drain();
        repeat (20) @(posedge aclk);

        $display("sent %0d pixels over %0d frame setups, checked %0d output pixels",
                 pixels_sent, frames_started, pixels_seen);
        $display("covered minimum/saturated geometry, threshold extremes and frame wrap");
        if (errors == 0) begin
            $display("tb_compass_sobel_edge_filter OK");
        end else begin
            $display("tb_compass_sobel_edge_filter NOT OK");
        end
        $finish;
    end
endmodule
